// ----- rtl/i2a_pkg.sv -----
// Package for the integer-to-ASCII formatter: constants, base codes,
// controller/datapath command and status structs, and the BCD adjust step.
// No dependencies.
package i2a_pkg;

  localparam int unsigned MAX_PRECISION = 32;
  localparam int unsigned VALUE_WIDTH   = 64;
  localparam int unsigned PREC_W        = 6;

  // Digit buffer: enough nibbles for 22 octal digits, 20 BCD digits or 16 hex digits.
  localparam int unsigned NUM_DIGITS = 22;
  localparam int unsigned DIG_W      = 4 * NUM_DIGITS;
  localparam int unsigned SZ_W       = 5;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned OCT_W      = 3 * NUM_DIGITS;
  localparam int unsigned HEX_DIGITS = VALUE_WIDTH / 4;

  // Two value bits enter the BCD register per conversion cycle.
  localparam int unsigned CONV_BITS  = 2;
  localparam int unsigned CONV_STEPS = VALUE_WIDTH / CONV_BITS;
  localparam int unsigned CNT_W      = $clog2(CONV_STEPS);

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_X_LOWER = 8'd120;
  localparam logic [7:0] CH_X_UPPER = 8'd88;
  localparam logic [7:0] HEX_OFF_UP = 8'd7;
  localparam logic [7:0] HEX_OFF_LO = 8'd39;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
    logic plan;
    logic emit;
  } i2a_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic conv_last;
    logic scan_done;
    logic empty;
    logic out_free;
    logic emit_last;
  } i2a_status_t;

  // One double-dabble step: adjust every BCD digit, then shift in one bit.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic in_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], in_bit};
  endfunction

endpackage

// ----- rtl/i2a_ctrl.sv -----
// Controller of the integer-to-ASCII formatter: one-hot sequencer that
// steps the datapath through conversion, digit scan, planning and output.
// Depends on i2a_pkg.
module i2a_ctrl
  import i2a_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  i2a_status_t status_i,
  output i2a_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_PLAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        // Octal and hex digits are already in place after the request is taken.
        cmd_o.conv = status_i.is_dec;
        if (!status_i.is_dec || status_i.conv_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_PLAN;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.empty) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/i2a_datapath.sv -----
// Datapath of the integer-to-ASCII formatter: request registers, digit
// buffer with BCD conversion, leading-zero scan, character select and
// the output register. Depends on i2a_pkg.
module i2a_datapath
  import i2a_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2a_cmd_t              cmd_i,
  output i2a_status_t           status_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                  is_negative_i,
  input  logic [1:0]            base_select_i,
  input  logic                  show_plus_i,
  input  logic                  show_space_i,
  input  logic                  alternate_form_i,
  input  logic                  uppercase_i,
  input  logic                  has_precision_i,
  input  logic [PREC_W-1:0]     precision_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_char_o,
  output logic                  out_last_o
);

  logic                   is_dec_q, is_oct_q, upper_q, sign_q, special_q;
  logic [7:0]             sign_char_q;
  logic [1:0]             pfx_q;
  logic [PREC_W-1:0]      wadj_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [DIG_W-1:0]       dig_q;
  logic [SZ_W-1:0]        sz_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [PREC_W-1:0]      b1_q, b2_q, b3_q, tot_q, k_q;
  logic                   out_valid_q;
  logic [7:0]             out_char_q;
  logic                   out_last_q;

  // Request decode.
  logic [PREC_W-1:0]  wsat, wadj;
  logic               in_oct, in_hex, in_sign, in_special;
  logic [1:0]         in_pfx;
  logic [DIG_W-1:0]   dig_load;
  logic [OCT_W-1:0]   oct_ext;

  always_comb begin
    in_oct  = (base_select_i == BASE_OCT);
    in_hex  = (base_select_i != BASE_OCT) && (base_select_i != BASE_DEC);
    in_sign = is_negative_i | show_space_i | show_plus_i;
    if (!has_precision_i) begin
      wsat = PREC_W'(1);
    end else if (precision_i > PREC_W'(MAX_PRECISION)) begin
      wsat = PREC_W'(MAX_PRECISION);
    end else begin
      wsat = precision_i;
    end
    in_special = has_precision_i && (wsat == '0) && (value_i == '0);
    wadj   = wsat;
    in_pfx = 2'd0;
    if (alternate_form_i && in_oct) begin
      in_pfx = 2'd1;
      if (wsat != '0) begin
        wadj = wsat - PREC_W'(1);
      end
    end else if (alternate_form_i && in_hex && !in_special) begin
      in_pfx = 2'd2;
      wadj   = (wsat > PREC_W'(1)) ? wsat - PREC_W'(2) : '0;
    end
    oct_ext  = OCT_W'(value_i);
    dig_load = '0;
    if (in_oct) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_load[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
      end
    end else if (in_hex) begin
      dig_load[VALUE_WIDTH-1:0] = value_i;
    end
  end

  // Two dabble steps per cycle.
  logic [BCD_W-1:0] bcd_step1, bcd_step2;
  always_comb begin
    bcd_step1 = dabble_step(dig_q[BCD_W-1:0], val_q[VALUE_WIDTH-1]);
    bcd_step2 = dabble_step(bcd_step1, val_q[VALUE_WIDTH-2]);
  end

  // Output plan.
  logic [SZ_W-1:0]   sz_eff;
  logic [PREC_W-1:0] pad, b1, b2, b3;
  always_comb begin
    sz_eff = special_q ? '0 : sz_q;
    pad    = (wadj_q > PREC_W'(sz_eff)) ? wadj_q - PREC_W'(sz_eff) : '0;
    b1     = PREC_W'(sign_q);
    b2     = b1 + PREC_W'(pfx_q);
    b3     = b2 + pad;
  end

  // Character select.
  logic [3:0] top_dig;
  logic [7:0] dig_char, chr;
  logic       is_digit;
  always_comb begin
    top_dig  = dig_q[DIG_W-1 -: 4];
    dig_char = CH_ZERO + 8'(top_dig);
    if (!is_oct_q && !is_dec_q && (top_dig > 4'd9)) begin
      dig_char = dig_char + (upper_q ? HEX_OFF_UP : HEX_OFF_LO);
    end
    is_digit = 1'b0;
    if (k_q < b1_q) begin
      chr = sign_char_q;
    end else if (k_q < b2_q) begin
      chr = (k_q == b1_q) ? CH_ZERO : (upper_q ? CH_X_UPPER : CH_X_LOWER);
    end else if (k_q < b3_q) begin
      chr = CH_ZERO;
    end else begin
      chr      = dig_char;
      is_digit = 1'b1;
    end
  end

  logic last_char;
  assign last_char = ((k_q + PREC_W'(1)) == tot_q);

  always_comb begin
    status_o.is_dec    = is_dec_q;
    status_o.conv_last = (cnt_q == '0);
    status_o.scan_done = (sz_q == SZ_W'(1)) || (top_dig != 4'd0);
    status_o.empty     = (tot_q == '0);
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.emit_last = last_char;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_dec_q  <= (base_select_i == BASE_DEC);
      is_oct_q  <= in_oct;
      upper_q   <= uppercase_i;
      sign_q    <= in_sign;
      special_q <= in_special;
      pfx_q     <= in_pfx;
      wadj_q    <= wadj;
      val_q     <= value_i;
      dig_q     <= dig_load;
      sz_q      <= SZ_W'(NUM_DIGITS);
      cnt_q     <= CNT_W'(CONV_STEPS - 1);
      if (is_negative_i) begin
        sign_char_q <= CH_MINUS;
      end else if (show_space_i) begin
        sign_char_q <= CH_SPACE;
      end else begin
        sign_char_q <= CH_PLUS;
      end
    end
    if (cmd_i.conv) begin
      dig_q <= DIG_W'(bcd_step2);
      val_q <= {val_q[VALUE_WIDTH-CONV_BITS-1:0], CONV_BITS'(0)};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.scan) begin
      dig_q <= {dig_q[DIG_W-5:0], 4'd0};
      sz_q  <= sz_q - SZ_W'(1);
    end
    if (cmd_i.plan) begin
      b1_q  <= b1;
      b2_q  <= b2;
      b3_q  <= b3;
      tot_q <= b3 + PREC_W'(sz_eff);
      k_q   <= '0;
    end
    if (cmd_i.emit) begin
      k_q        <= k_q + PREC_W'(1);
      out_char_q <= chr;
      out_last_q <= last_char;
      if (is_digit) begin
        dig_q <= {dig_q[DIG_W-5:0], 4'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/integer_to_ascii_formatter_top.sv -----
// Channel   Dir  Signals                         Contents
// request   in   s_axis_tvalid/tready/tdata/tuser  number and conversion flags
// character out  m_axis_tvalid/tready/tdata/tlast  one ASCII character per beat
//
// A request is taken and converted (octal and hex digits load directly; decimal shifts
// two bits per cycle through the BCD shift register), leading zeros are scanned off,
// the output is planned, then one character leaves per unstalled cycle (at most 33).
// The next request is taken once the last character has entered the output register.
// Reset is asynchronous and active low; it empties the output register.
// A stalled output holds the character and pauses the sequencer.
// Top level of the integer-to-ASCII formatter; depends on i2a_pkg, i2a_ctrl
// and i2a_datapath.
module integer_to_ascii_formatter_top
  import i2a_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [63:0] value, [64] is_negative, [65] show_plus, [66] show_space,
  // [67] alternate_form, [68] uppercase, [69] has_precision, [75:70] precision,
  // [79:76] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] base_select
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] out_char
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  i2a_cmd_t    cmd;
  i2a_status_t status;

  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2a_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .value_i          (s_axis_tdata[VALUE_WIDTH-1:0]),
    .is_negative_i    (s_axis_tdata[VALUE_WIDTH]),
    .base_select_i    (s_axis_tuser),
    .show_plus_i      (s_axis_tdata[VALUE_WIDTH+1]),
    .show_space_i     (s_axis_tdata[VALUE_WIDTH+2]),
    .alternate_form_i (s_axis_tdata[VALUE_WIDTH+3]),
    .uppercase_i      (s_axis_tdata[VALUE_WIDTH+4]),
    .has_precision_i  (s_axis_tdata[VALUE_WIDTH+5]),
    .precision_i      (s_axis_tdata[VALUE_WIDTH+6 +: PREC_W]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_char_o       (m_axis_tdata),
    .out_last_o       (m_axis_tlast)
  );

endmodule

// ----- sim/integer_to_ascii_formatter_top_tb.sv -----
// Testbench for integer_to_ascii_formatter_top: sends numbers with printf-style flags and
// checks every emitted character and its last mark against a predictor in the bench.
// Depends on i2a_pkg and the formatter RTL.
module integer_to_ascii_formatter_top_tb
  import i2a_pkg::*;
();

  localparam logic [1:0] BASE_HEX_ALIAS = 2'd3;  // treated as hexadecimal
  localparam int unsigned DRAIN_CYCLES  = 150;
  localparam int unsigned RUN_LIMIT     = 4 * 600000;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   neg;
    logic [1:0]             base;
    logic                   plus;
    logic                   space;
    logic                   alt;
    logic                   upper;
    logic                   has_prec;
    logic [PREC_W-1:0]      prec;
  } number_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  char_beat_t  expected_chars[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left = 0;

  integer_to_ascii_formatter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Works out the characters of one conversion and queues them in order.
  function automatic void predict_chars(input number_req_t r);
    logic [7:0]             line[$];
    logic [7:0]             digs[$];
    logic [VALUE_WIDTH-1:0] v;
    logic [3:0]             nib;
    logic [7:0]             off;
    logic                   is_oct;
    logic                   is_hex;
    int unsigned            w;
    v = r.value;
    is_oct = (r.base == BASE_OCT);
    is_hex = (r.base == BASE_HEX) || (r.base == BASE_HEX_ALIAS);
    if (r.neg) begin
      line.push_back(CH_MINUS);
    end else if (r.space) begin
      line.push_back(CH_SPACE);
    end else if (r.plus) begin
      line.push_back(CH_PLUS);
    end
    if (r.has_prec) begin
      w = (r.prec > MAX_PRECISION) ? MAX_PRECISION : r.prec;
    end else begin
      w = 1;
    end
    if (r.has_prec && w == 0 && v == 0) begin
      if (r.alt && is_oct) begin
        line.push_back(CH_ZERO);
      end
    end else begin
      if (r.alt && is_oct) begin
        line.push_back(CH_ZERO);
        if (w > 0) begin
          w--;
        end
      end else if (r.alt && is_hex) begin
        line.push_back(CH_ZERO);
        line.push_back(r.upper ? CH_X_UPPER : CH_X_LOWER);
        w = (w > 1) ? w - 2 : 0;
      end
      if (v == 0) begin
        digs.push_front(CH_ZERO);
      end
      while (v != 0) begin
        if (is_oct) begin
          digs.push_front(CH_ZERO + 8'(v[2:0]));
          v = v >> 3;
        end else if (is_hex) begin
          nib = v[3:0];
          off = (nib > 4'd9) ? (r.upper ? HEX_OFF_UP : HEX_OFF_LO) : 8'd0;
          digs.push_front(CH_ZERO + off + 8'(nib));
          v = v >> 4;
        end else begin
          digs.push_front(CH_ZERO + 8'(v % 10));
          v = v / 10;
        end
      end
      while (w > digs.size()) begin
        line.push_back(CH_ZERO);
        w--;
      end
      foreach (digs[i]) begin
        line.push_back(digs[i]);
      end
    end
    foreach (line[i]) begin
      expected_chars.push_back('{ch: line[i], last: (i == line.size() - 1)});
    end
  endfunction

  function automatic number_req_t make_req(input logic [VALUE_WIDTH-1:0] value,
                                           input logic [1:0] base, input int unsigned neg,
                                           input int unsigned plus,
                                           input int unsigned space,
                                           input int unsigned alt,
                                           input int unsigned upper,
                                           input int unsigned has_prec,
                                           input int unsigned prec);
    number_req_t r;
    r.value = value;
    r.base = base;
    r.neg = 1'(neg);
    r.plus = 1'(plus);
    r.space = 1'(space);
    r.alt = 1'(alt);
    r.upper = 1'(upper);
    r.has_prec = 1'(has_prec);
    r.prec = PREC_W'(prec);
    return r;
  endfunction

  // Values spread over all magnitudes, with zero and the largest value often.
  function automatic number_req_t random_req();
    number_req_t r;
    r.value = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r.value = '0;
      1: r.value = '1;
      2, 3, 4: r.value = r.value >> $urandom_range(0, VALUE_WIDTH - 1);
      default: ;
    endcase
    r.base = 2'($urandom_range(0, 3));
    r.neg = 1'($urandom_range(0, 1));
    r.plus = 1'($urandom_range(0, 1));
    r.space = ($urandom_range(0, 3) == 0);
    r.alt = 1'($urandom_range(0, 1));
    r.upper = 1'($urandom_range(0, 1));
    r.has_prec = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      r.prec = PREC_W'($urandom_range(0, 63));
    end else begin
      r.prec = PREC_W'($urandom_range(0, 12));
    end
    return r;
  endfunction

  task automatic send_number(input number_req_t r);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, r.prec, r.has_prec, r.upper, r.alt, r.space, r.plus, r.neg,
                     r.value};
    s_axis_tuser <= r.base;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_chars(r);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Also covers requests that emit nothing and so leave no expectation behind.
  task automatic wait_for_drain();
    release_input();
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_number(make_req(64'd0, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
    send_number(make_req('1, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
    send_number(make_req('1, BASE_OCT, 0, 0, 0, 1, 0, 0, 0));
    send_number(make_req('1, BASE_HEX, 0, 0, 0, 1, 1, 0, 0));
    send_number(make_req('1, BASE_HEX, 0, 0, 0, 1, 0, 0, 0));
    send_number(make_req(64'hDEADBEEF, BASE_HEX, 0, 0, 0, 0, 0, 0, 0));
    // Zero with precision zero: only the octal alternate form prints a digit.
    send_number(make_req(64'd0, BASE_OCT, 0, 0, 0, 1, 0, 1, 0));
    send_number(make_req(64'd0, BASE_DEC, 0, 0, 0, 0, 0, 1, 0));
    send_number(make_req(64'd0, BASE_HEX, 0, 1, 0, 1, 0, 1, 0));
    send_number(make_req(64'd0, BASE_HEX, 0, 0, 0, 1, 0, 1, 5));
    send_number(make_req(64'd0, BASE_HEX, 0, 0, 0, 1, 1, 0, 0));
    send_number(make_req(64'd5, BASE_OCT, 0, 0, 0, 1, 0, 1, 1));
    send_number(make_req(64'd123, BASE_DEC, 1, 1, 1, 0, 0, 0, 0));
    send_number(make_req(64'd123, BASE_DEC, 0, 1, 1, 0, 0, 0, 0));
    send_number(make_req(64'd123, BASE_DEC, 0, 1, 0, 0, 0, 0, 0));
    send_number(make_req(64'd42, BASE_DEC, 0, 0, 0, 0, 0, 1, 32));
    send_number(make_req(64'd42, BASE_DEC, 0, 0, 0, 0, 0, 1, 63));
    send_number(make_req(64'd42, BASE_HEX_ALIAS, 0, 0, 0, 1, 1, 0, 0));
    send_number(make_req(64'd7, BASE_OCT, 0, 0, 1, 0, 0, 1, 33));
    send_number(make_req(64'd1, BASE_HEX, 0, 0, 0, 1, 0, 1, 1));
    send_number(make_req(64'h8000_0000_0000_0000, BASE_OCT, 0, 0, 0, 0, 0, 0, 0));
    send_number(make_req(64'hFEDC_BA98_7654_3210, BASE_HEX, 0, 0, 0, 0, 1, 0, 0));
    // A precision without its enable is ignored.
    send_number(make_req(64'd10, BASE_DEC, 0, 0, 0, 1, 0, 0, 40));
    // Longest output: sign, twelve pad zeros and twenty digits.
    send_number(make_req('1, BASE_DEC, 1, 0, 0, 0, 0, 1, 32));
    wait_for_drain();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_number(random_req());
    wait_for_drain();
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 400;
    repeat (6) send_number(random_req());
    wait_for_drain();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 20;
    repeat (4) send_number(random_req());
    wait_for_drain();
    repeat (4) send_number(random_req());
    wait_for_drain();
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $error("out_char: none expected, got 0x%02h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char: expected 0x%02h, got 0x%02h", want.ch, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(30, 34, 80);
    test_random(30, 80, 34);
    test_random(30, 0, 0);
    test_output_stall();
    test_sender_pause();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
